[hdl/bmmd_pkg.sv]
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared types and constants for the binary mask majority downsampler.
// ----------------------------------------------------------------------------
package bmmd_pkg;

  // Default sizing of the line store and block factor
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxFactor = 64;

  // Fixed field widths
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 16;
  localparam int unsigned CfgFactorW = 7;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned OutRowW    = 16;
  localparam int unsigned OutColW    = 10;

  // Register reset values
  localparam logic [CfgWidthW-1:0]  RstWidth  = 11'd1024;
  localparam logic [CfgHeightW-1:0] RstHeight = 16'd1;
  localparam logic [CfgFactorW-1:0] RstFactor = 7'd1;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1,
    RegBlockFactor = 2'd2
  } cfg_reg_e;

endpackage

[hdl/bmmd_line_buf.sv]
// ----------------------------------------------------------------------------
// bmmd_line_buf
// Per-block-column hit sum store: one write port, one registered read port,
// with forwarding of a write that lands on the address read at the same edge.
// ----------------------------------------------------------------------------
module bmmd_line_buf #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned DataW = 13
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [DataW-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [DataW-1:0]         rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] fwd_data_q;
  logic             fwd_hit_q;

  // Storage array, read-before-write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= mem[rd_addr_i];
    fwd_data_q <= wr_data_i;
  end

  // Same-edge write/read collision tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

[hdl/binary_mask_majority_downsample_top.sv]
// ----------------------------------------------------------------------------
// binary_mask_majority_downsample_top
// Reduces a raster binary mask by k-by-k majority vote, one pixel a cycle while the output register is free.
//
//   channel | direction | signals                                 | transfer
//   --------+-----------+-----------------------------------------+----------
//   in      | input     | in_valid_i/in_ready_o, mask_bit_i        | valid&ready
//   out     | output    | out_valid_o/out_ready_i, covered_o,      | valid&ready
//           |           | out_row_o, out_col_o, last_of_image_o    |
//   cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i          | we high
//
// One pixel is taken every cycle while the output register is free; a result
// appears in the output register the cycle after the pixel that closes a
// block. The line store is read ahead at the next block column through its
// registered read port. The output register holds a result while the sink
// stalls and input is taken again as soon as it is free. Reset clears the
// position counters and loads default registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_mask_majority_downsample_top #(
  parameter int unsigned MAX_WIDTH  = bmmd_pkg::DefMaxWidth,
  parameter int unsigned MAX_FACTOR = bmmd_pkg::DefMaxFactor
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bmmd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bmmd_pkg::CfgDataW-1:0]     cfg_data_i,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mask_bit_i,
  // reduced pixel output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              covered_o,
  output logic [bmmd_pkg::OutRowW-1:0]      out_row_o,
  output logic [bmmd_pkg::OutColW-1:0]      out_col_o,
  output logic                              last_of_image_o
);

  import bmmd_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned EwW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CbW  = $clog2(MAX_FACTOR);
  localparam int unsigned KW   = $clog2(MAX_FACTOR + 1);
  localparam int unsigned SW   = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

  // Configuration registers
  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [CfgFactorW-1:0] factor_q;

  // Position state
  logic [ColW-1:0]       pixel_col_q, pixel_col_d;
  logic [CfgHeightW-1:0] pixel_row_q, pixel_row_d;
  logic [CbW-1:0]        col_in_blk_q, col_in_blk_d;
  logic [CbW-1:0]        row_in_blk_q, row_in_blk_d;
  logic [ColW-1:0]       block_col_q, block_col_d;
  logic [OutRowW-1:0]    block_row_q, block_row_d;
  logic [KW-1:0]         row_hits_q, row_hits_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic                  covered_q;
  logic [OutRowW-1:0]    out_row_q;
  logic [OutColW-1:0]    out_col_q;
  logic                  last_q;

  logic                  in_xfer;
  logic                  cfg_hit;
  logic [EwW-1:0]        eff_w;
  logic [CfgHeightW-1:0] eff_h;
  logic [KW-1:0]         eff_k;
  logic                  last_col, last_row, col_wrap, row_wrap;
  logic                  blk_col_done, blk_row_done, emit;
  logic [KW-1:0]         hits_now;
  logic [SW-1:0]         stored_sum, sum;
  logic [SW-1:0]         total;
  logic                  covered_now;
  logic                  wr_en;

  // Effective register values (zero becomes one, oversize width and factor saturate)
  always_comb begin
    if (width_q == '0) begin
      eff_w = EwW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = EwW'(MAX_WIDTH);
    end else begin
      eff_w = EwW'(width_q);
    end
    eff_h = (height_q == '0) ? CfgHeightW'(1) : height_q;
    if (factor_q == '0) begin
      eff_k = KW'(1);
    end else if (32'(factor_q) > MAX_FACTOR) begin
      eff_k = KW'(MAX_FACTOR);
    end else begin
      eff_k = KW'(factor_q);
    end
  end

  // Position flags
  assign last_col     = (EwW'(pixel_col_q) + EwW'(1)) >= eff_w;
  assign last_row     = ({1'b0, pixel_row_q} + 17'd1) >= {1'b0, eff_h};
  assign col_wrap     = (KW'(col_in_blk_q) + KW'(1)) >= eff_k;
  assign row_wrap     = (KW'(row_in_blk_q) + KW'(1)) >= eff_k;
  assign blk_col_done = last_col || col_wrap;
  assign blk_row_done = last_row || row_wrap;
  assign emit         = blk_col_done && blk_row_done;

  // Handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == RegImageWidth) ||
                                   (cfg_idx_i == RegImageHeight) ||
                                   (cfg_idx_i == RegBlockFactor));

  // Hit accumulation and majority decision
  assign hits_now    = ((col_in_blk_q == '0) ? KW'(0) : row_hits_q) + KW'(mask_bit_i);
  assign sum         = ((row_in_blk_q == '0) ? SW'(0) : stored_sum) + SW'(hits_now);
  assign total       = SW'((SW'(col_in_blk_q) + SW'(1)) * (SW'(row_in_blk_q) + SW'(1)));
  assign covered_now = {sum, 1'b0} >= {1'b0, total};
  assign wr_en       = in_xfer && blk_col_done && !blk_row_done;

  // Next position
  always_comb begin
    pixel_col_d  = pixel_col_q;
    pixel_row_d  = pixel_row_q;
    col_in_blk_d = col_in_blk_q;
    row_in_blk_d = row_in_blk_q;
    block_col_d  = block_col_q;
    block_row_d  = block_row_q;
    row_hits_d   = row_hits_q;
    if (cfg_hit) begin
      pixel_col_d  = '0;
      pixel_row_d  = '0;
      col_in_blk_d = '0;
      row_in_blk_d = '0;
      block_col_d  = '0;
      block_row_d  = '0;
      row_hits_d   = '0;
    end else if (in_xfer) begin
      row_hits_d = blk_col_done ? KW'(0) : hits_now;
      if (last_col) begin
        pixel_col_d  = '0;
        col_in_blk_d = '0;
        block_col_d  = '0;
        if (last_row) begin
          pixel_row_d  = '0;
          row_in_blk_d = '0;
          block_row_d  = '0;
          row_hits_d   = '0;
        end else begin
          pixel_row_d = pixel_row_q + 1'b1;
          if (row_wrap) begin
            row_in_blk_d = '0;
            block_row_d  = block_row_q + 1'b1;
          end else begin
            row_in_blk_d = row_in_blk_q + 1'b1;
          end
        end
      end else begin
        pixel_col_d = pixel_col_q + 1'b1;
        if (col_wrap) begin
          col_in_blk_d = '0;
          block_col_d  = block_col_q + 1'b1;
        end else begin
          col_in_blk_d = col_in_blk_q + 1'b1;
        end
      end
    end
  end

  // Output register next valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      out_valid_d = in_xfer && emit;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= RstWidth;
      height_q     <= RstHeight;
      factor_q     <= RstFactor;
      pixel_col_q  <= '0;
      pixel_row_q  <= '0;
      col_in_blk_q <= '0;
      row_in_blk_q <= '0;
      block_col_q  <= '0;
      block_row_q  <= '0;
      row_hits_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegImageWidth:  width_q  <= cfg_data_i[CfgWidthW-1:0];
          RegImageHeight: height_q <= cfg_data_i[CfgHeightW-1:0];
          RegBlockFactor: factor_q <= cfg_data_i[CfgFactorW-1:0];
          default: ;
        endcase
      end
      pixel_col_q  <= pixel_col_d;
      pixel_row_q  <= pixel_row_d;
      col_in_blk_q <= col_in_blk_d;
      row_in_blk_q <= row_in_blk_d;
      block_col_q  <= block_col_d;
      block_row_q  <= block_row_d;
      row_hits_q   <= row_hits_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload, loaded on a closing pixel
  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      covered_q <= covered_now;
      out_row_q <= block_row_q;
      out_col_q <= OutColW'(block_col_q);
      last_q    <= last_col && last_row;
    end
  end

  // Line store: read ahead at the next pixel's block column
  bmmd_line_buf #(
    .Depth (MAX_WIDTH),
    .DataW (SW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (block_col_q),
    .wr_data_i (sum),
    .rd_addr_i (block_col_d),
    .rd_data_o (stored_sum)
  );

  assign out_valid_o     = out_valid_q;
  assign covered_o       = covered_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign last_of_image_o = last_q;

endmodule
